// ===== sv/bmp565_pkg.sv =====
// Shared types and constants of the BMP 24-bpp to RGB565 stream decoder.
package bmp565_pkg;

	// Payload widths
	localparam int BYTE_W  = 8;
	localparam int DIM_W   = 10;
	localparam int PIX_W   = 16;
	localparam int KIND_W  = 2;
	localparam int ERR_W   = 2;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] PANEL_WIDTH_RST  = 10'd800;
	localparam logic [DIM_W-1:0] PANEL_HEIGHT_RST = 10'd480;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_PIXEL    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACCEPT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd3;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_HEADER      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_UNSUPPORTED = 2'd1;
	localparam logic [ERR_W-1:0] ERR_TOO_LARGE   = 2'd2;
	localparam logic [ERR_W-1:0] ERR_TRUNCATED   = 2'd3;

	// Header layout
	localparam int HDR_LEN    = 54;
	localparam int POS_SIG_B  = 0;
	localparam int POS_SIG_M  = 1;
	localparam int POS_OFFSET = 10;
	localparam int POS_WIDTH  = 18;
	localparam int POS_HEIGHT = 22;
	localparam int POS_BPP    = 28;
	localparam int POS_COMP   = 30;

	localparam logic [7:0]  SIG_B  = 8'h42;
	localparam logic [7:0]  SIG_M  = 8'h4D;
	localparam logic [15:0] BPP_24 = 16'd24;

	// Result queue
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_SKIP   = 5'b00010,
		PH_PIXEL  = 5'b00100,
		PH_PAD    = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [PIX_W-1:0]  pixel_rgb565;
		logic [DIM_W-1:0]  screen_x;
		logic [DIM_W-1:0]  screen_y;
		logic              clear_region;
		logic [DIM_W-1:0]  image_width;
		logic [DIM_W-1:0]  image_height;
		logic [ERR_W-1:0]  error_code;
		logic              run_last;
	} result_t;

endpackage

// ===== sv/bmp565_ifs.sv =====
// Stream and configuration channel interfaces of the BMP to RGB565 decoder.
interface bmp565_byte_if;
	logic                            valid;
	logic                            ready;
	logic [bmp565_pkg::BYTE_W-1:0]   data_byte;
	logic                            file_end;

	modport source (output valid, output data_byte, output file_end, input ready);
	modport sink (input valid, input data_byte, input file_end, output ready);
endinterface

interface bmp565_result_if;
	logic                            valid;
	logic                            ready;
	logic [bmp565_pkg::KIND_W-1:0]   result_kind;
	logic [bmp565_pkg::PIX_W-1:0]    pixel_rgb565;
	logic [bmp565_pkg::DIM_W-1:0]    screen_x;
	logic [bmp565_pkg::DIM_W-1:0]    screen_y;
	logic                            clear_region;
	logic [bmp565_pkg::DIM_W-1:0]    image_width;
	logic [bmp565_pkg::DIM_W-1:0]    image_height;
	logic [bmp565_pkg::ERR_W-1:0]    error_code;
	logic                            run_last;

	modport source (output valid, output result_kind, output pixel_rgb565, output screen_x,
		output screen_y, output clear_region, output image_width, output image_height,
		output error_code, output run_last, input ready);
	modport sink (input valid, input result_kind, input pixel_rgb565, input screen_x,
		input screen_y, input clear_region, input image_width, input image_height,
		input error_code, input run_last, output ready);
endinterface

interface bmp565_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bmp565_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [bmp565_pkg::DIM_W-1:0]      wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== sv/bmp24_stream_to_rgb565_top.sv =====
// Top level of the BMP 24-bpp byte stream to RGB565 pixel decoder.
//
// Usage:
//   bytes   : one BMP file byte per transaction, file_end set on the last byte.
//   results : pixels (kind 0) with centred screen coordinates, header accept
//             (kind 1, with image size and clear_region), image complete
//             (kind 2) or error (kind 3, error_code). run_last marks the final
//             result caused by one input byte; a byte causes zero, one or two.
//   cfg     : panel_width (index 0) and panel_height (index 1); always ready.
//             Write only while the decoder is idle; sizes are taken at accept.
// Timing: a byte's results appear on the result channel from the cycle after
//   its handshake. One byte per cycle is sustained while the result queue has
//   room for two results; the state update per byte is one short add/compare
//   step between the byte handshake and a four-entry result queue.
// Stall: bytes.ready drops only while fewer than two queue slots are free, so
//   a stalled receiver stops input after at most four further results.
// Reset: arst_n clears the decoder to the start of a file, empties the queue
//   and restores the panel size to 800 by 480. After file_end the next byte
//   starts a new file.
module bmp24_stream_to_rgb565_top #(
	parameter int MAX_WIDTH  = 800,
	parameter int MAX_HEIGHT = 1023
) (
	input  logic                    clk,
	input  logic                    arst_n,
	bmp565_byte_if.sink             bytes,
	bmp565_result_if.source         results,
	bmp565_cfg_if.sink              cfg
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [bmp565_pkg::DIM_W-1:0] pw_q, ph_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q <= bmp565_pkg::PANEL_WIDTH_RST;
			ph_q <= bmp565_pkg::PANEL_HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				bmp565_pkg::REG_PANEL_WIDTH:  pw_q <= cfg.wr_data;
				bmp565_pkg::REG_PANEL_HEIGHT: ph_q <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Decoder state
	// ------------------------------------------------------------------
	bmp565_pkg::phase_t           phase_q, phase_d;
	logic [31:0]                  pos_q, pos_d;
	logic [31:0]                  offset_q;
	logic [31:0]                  rw_q, rh_q;
	logic [15:0]                  bpp_q;
	logic                         comp_nz_q, comp_nz_d;
	logic                         sig_ok_q, sig_ok_d;
	logic                         top_down_q, top_down_d;
	logic [bmp565_pkg::DIM_W-1:0] col_q, col_d, row_q, row_d;
	logic [1:0]                   bip_q, bip_d;
	logic [15:0]                  bg_q;
	logic [1:0]                   pad_q, pad_d;
	logic [bmp565_pkg::DIM_W-1:0] offx_q, offy_q, img_w_q, img_h_q;

	logic                         byte_acc;
	logic [7:0]                   b;
	logic [5:0]                   hp;
	logic                         hdr_load, end_row, restart;

	// Result queue
	bmp565_pkg::result_t          q_mem [bmp565_pkg::Q_DEPTH];
	logic [bmp565_pkg::Q_AW-1:0]  wr_q, rd_q;
	logic [bmp565_pkg::Q_CW-1:0]  cnt_q;
	bmp565_pkg::result_t          res_v [2];
	logic [1:0]                   res_n;
	logic                         pop;

	assign b        = bytes.data_byte;
	assign hp       = pos_q[5:0];
	assign byte_acc = bytes.valid && bytes.ready;

	// ------------------------------------------------------------------
	// Header checks: all fields are in registers by the last header byte
	// ------------------------------------------------------------------
	logic                         h_neg, bad_fmt, too_big, clr;
	logic [31:0]                  h_mag;
	logic [bmp565_pkg::DIM_W-1:0] offx_new, offy_new;

	assign h_neg = rh_q[31];
	assign h_mag = h_neg ? (~rh_q + 32'd1) : rh_q;

	// The most negative height keeps bit 31 after negation: unsupported
	assign bad_fmt = (bpp_q != bmp565_pkg::BPP_24) || comp_nz_q || (rw_q == 32'd0) ||
		rw_q[31] || (h_mag == 32'd0) || h_mag[31];
	assign too_big = (rw_q > 32'(pw_q)) || (h_mag > 32'(ph_q)) ||
		(rw_q > 32'(MAX_WIDTH)) || (h_mag > 32'(MAX_HEIGHT));
	assign clr      = (rw_q[9:0] < pw_q) || (h_mag[9:0] < ph_q);
	assign offx_new = (pw_q - rw_q[9:0]) >> 1;
	assign offy_new = (ph_q - h_mag[9:0]) >> 1;

	// ------------------------------------------------------------------
	// Pixel assembly and placement
	// ------------------------------------------------------------------
	logic [bmp565_pkg::PIX_W-1:0] pix;
	logic [bmp565_pkg::DIM_W-1:0] pix_x, pix_y, col_p1, row_p1;

	assign pix    = {b[7:3], bg_q[15:10], bg_q[7:3]};
	assign pix_x  = offx_q + col_q;
	// Flip bottom-up images so the first stored row lands at the bottom
	assign pix_y  = offy_q + (top_down_q ? row_q : (img_h_q - 10'd1 - row_q));
	assign col_p1 = col_q + 10'd1;
	assign row_p1 = row_q + 10'd1;

	function automatic bmp565_pkg::result_t mk_res(
		input logic [bmp565_pkg::KIND_W-1:0] kind,
		input logic [bmp565_pkg::PIX_W-1:0]  p,
		input logic [bmp565_pkg::DIM_W-1:0]  x,
		input logic [bmp565_pkg::DIM_W-1:0]  y,
		input logic                          c,
		input logic [bmp565_pkg::DIM_W-1:0]  iw,
		input logic [bmp565_pkg::DIM_W-1:0]  ih,
		input logic [bmp565_pkg::ERR_W-1:0]  err
	);
		bmp565_pkg::result_t r;
		r.result_kind  = kind;
		r.pixel_rgb565 = p;
		r.screen_x     = x;
		r.screen_y     = y;
		r.clear_region = c;
		r.image_width  = iw;
		r.image_height = ih;
		r.error_code   = err;
		r.run_last     = 1'b0;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Next state and results of the byte on the input
	// ------------------------------------------------------------------
	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		sig_ok_d   = sig_ok_q;
		comp_nz_d  = comp_nz_q;
		top_down_d = top_down_q;
		col_d      = col_q;
		row_d      = row_q;
		bip_d      = bip_q;
		pad_d      = pad_q;
		hdr_load   = 1'b0;
		end_row    = 1'b0;
		restart    = 1'b0;
		res_n      = 2'd0;
		res_v[0]   = '0;
		res_v[1]   = '0;

		case (phase_q)
			bmp565_pkg::PH_HEADER: begin
				pos_d = pos_q + 32'd1;
				if (hp == 6'(bmp565_pkg::POS_SIG_B) && b != bmp565_pkg::SIG_B)
					sig_ok_d = 1'b0;
				if (hp == 6'(bmp565_pkg::POS_SIG_M) && b != bmp565_pkg::SIG_M)
					sig_ok_d = 1'b0;
				if (hp >= 6'(bmp565_pkg::POS_COMP) && hp <= 6'(bmp565_pkg::POS_COMP + 3) &&
						b != 8'd0)
					comp_nz_d = 1'b1;
				if (hp == 6'(bmp565_pkg::HDR_LEN - 1)) begin
					if (!sig_ok_q) begin
						res_v[res_n[0]] = mk_res(bmp565_pkg::KIND_ERROR, '0, '0, '0, 1'b0,
							'0, '0, bmp565_pkg::ERR_HEADER);
						res_n   = res_n + 2'd1;
						phase_d = bmp565_pkg::PH_DONE;
					end else if (bad_fmt) begin
						res_v[res_n[0]] = mk_res(bmp565_pkg::KIND_ERROR, '0, '0, '0, 1'b0,
							'0, '0, bmp565_pkg::ERR_UNSUPPORTED);
						res_n   = res_n + 2'd1;
						phase_d = bmp565_pkg::PH_DONE;
					end else if (too_big) begin
						res_v[res_n[0]] = mk_res(bmp565_pkg::KIND_ERROR, '0, '0, '0, 1'b0,
							'0, '0, bmp565_pkg::ERR_TOO_LARGE);
						res_n   = res_n + 2'd1;
						phase_d = bmp565_pkg::PH_DONE;
					end else begin
						res_v[res_n[0]] = mk_res(bmp565_pkg::KIND_ACCEPT, '0, '0, '0, clr,
							rw_q[9:0], h_mag[9:0], bmp565_pkg::ERR_HEADER);
						res_n      = res_n + 2'd1;
						hdr_load   = 1'b1;
						top_down_d = h_neg;
						// A small offset starts pixels right after the header
						phase_d = (offset_q <= 32'(bmp565_pkg::HDR_LEN)) ?
							bmp565_pkg::PH_PIXEL : bmp565_pkg::PH_SKIP;
					end
				end
			end
			bmp565_pkg::PH_SKIP: begin
				pos_d = pos_q + 32'd1;
				if (pos_d == offset_q)
					phase_d = bmp565_pkg::PH_PIXEL;
			end
			bmp565_pkg::PH_PIXEL: begin
				case (bip_q)
					2'd0: bip_d = 2'd1;
					2'd1: bip_d = 2'd2;
					default: begin
						bip_d = 2'd0;
						res_v[res_n[0]] = mk_res(bmp565_pkg::KIND_PIXEL, pix, pix_x, pix_y,
							1'b0, '0, '0, bmp565_pkg::ERR_HEADER);
						res_n = res_n + 2'd1;
						if (col_p1 == img_w_q) begin
							col_d = '0;
							pad_d = img_w_q[1:0];
							if (img_w_q[1:0] == 2'd0)
								end_row = 1'b1;
							else
								phase_d = bmp565_pkg::PH_PAD;
						end else begin
							col_d = col_p1;
						end
					end
				endcase
			end
			bmp565_pkg::PH_PAD: begin
				// Drop row padding
				pad_d = pad_q - 2'd1;
				if (pad_q == 2'd1)
					end_row = 1'b1;
			end
			default: ;
		endcase

		if (end_row) begin
			row_d   = row_p1;
			phase_d = bmp565_pkg::PH_PIXEL;
			if (row_p1 == img_h_q) begin
				res_v[res_n[0]] = mk_res(bmp565_pkg::KIND_COMPLETE, '0, '0, '0, 1'b0,
					'0, '0, bmp565_pkg::ERR_HEADER);
				res_n   = res_n + 2'd1;
				phase_d = bmp565_pkg::PH_DONE;
			end
		end

		// File end: report an unfinished file, then start over
		if (bytes.file_end) begin
			if (phase_d != bmp565_pkg::PH_DONE) begin
				res_v[res_n[0]] = mk_res(bmp565_pkg::KIND_ERROR, '0, '0, '0, 1'b0, '0, '0,
					(phase_d == bmp565_pkg::PH_HEADER) ? bmp565_pkg::ERR_HEADER :
					bmp565_pkg::ERR_TRUNCATED);
				res_n = res_n + 2'd1;
			end
			restart = 1'b1;
		end

		if (res_n == 2'd1)
			res_v[0].run_last = 1'b1;
		else if (res_n == 2'd2)
			res_v[1].run_last = 1'b1;
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= bmp565_pkg::PH_HEADER;
			pos_q      <= '0;
			sig_ok_q   <= 1'b1;
			comp_nz_q  <= 1'b0;
			top_down_q <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			bip_q      <= '0;
			pad_q      <= '0;
		end else if (byte_acc) begin
			if (restart) begin
				phase_q    <= bmp565_pkg::PH_HEADER;
				pos_q      <= '0;
				sig_ok_q   <= 1'b1;
				comp_nz_q  <= 1'b0;
				top_down_q <= 1'b0;
				col_q      <= '0;
				row_q      <= '0;
				bip_q      <= '0;
				pad_q      <= '0;
			end else begin
				phase_q    <= phase_d;
				pos_q      <= pos_d;
				sig_ok_q   <= sig_ok_d;
				comp_nz_q  <= comp_nz_d;
				top_down_q <= top_down_d;
				col_q      <= col_d;
				row_q      <= row_d;
				bip_q      <= bip_d;
				pad_q      <= pad_d;
			end
		end
	end

	// ------------------------------------------------------------------
	// Header fields, pixel bytes and image geometry
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (byte_acc && phase_q == bmp565_pkg::PH_HEADER) begin
			if (hp >= 6'(bmp565_pkg::POS_OFFSET) && hp <= 6'(bmp565_pkg::POS_OFFSET + 3))
				offset_q[8*(2'(hp - 6'(bmp565_pkg::POS_OFFSET))) +: 8] <= b;
			if (hp >= 6'(bmp565_pkg::POS_WIDTH) && hp <= 6'(bmp565_pkg::POS_WIDTH + 3))
				rw_q[8*(2'(hp - 6'(bmp565_pkg::POS_WIDTH))) +: 8] <= b;
			if (hp >= 6'(bmp565_pkg::POS_HEIGHT) && hp <= 6'(bmp565_pkg::POS_HEIGHT + 3))
				rh_q[8*(2'(hp - 6'(bmp565_pkg::POS_HEIGHT))) +: 8] <= b;
			if (hp >= 6'(bmp565_pkg::POS_BPP) && hp <= 6'(bmp565_pkg::POS_BPP + 1))
				bpp_q[8*(1'(hp - 6'(bmp565_pkg::POS_BPP))) +: 8] <= b;
		end
		if (byte_acc && hdr_load) begin
			img_w_q <= rw_q[9:0];
			img_h_q <= h_mag[9:0];
			offx_q  <= offx_new;
			offy_q  <= offy_new;
		end
		// Hold blue then green until red arrives
		if (byte_acc && phase_q == bmp565_pkg::PH_PIXEL) begin
			if (bip_q == 2'd0)
				bg_q[7:0] <= b;
			else if (bip_q == 2'd1)
				bg_q[15:8] <= b;
		end
	end

	// ------------------------------------------------------------------
	// Result queue: admit a byte only with room for two results
	// ------------------------------------------------------------------
	assign bytes.ready = (cnt_q <= bmp565_pkg::Q_CW'(bmp565_pkg::Q_DEPTH - 2));
	assign pop         = results.valid && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (byte_acc)
				wr_q <= wr_q + bmp565_pkg::Q_AW'(res_n);
			if (pop)
				rd_q <= rd_q + bmp565_pkg::Q_AW'(1);
			cnt_q <= cnt_q + (byte_acc ? bmp565_pkg::Q_CW'(res_n) : '0) -
				bmp565_pkg::Q_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc && res_n != 2'd0)
			q_mem[wr_q] <= res_v[0];
		if (byte_acc && res_n == 2'd2)
			q_mem[wr_q + bmp565_pkg::Q_AW'(1)] <= res_v[1];
	end

	assign results.valid        = (cnt_q != '0);
	assign results.result_kind  = q_mem[rd_q].result_kind;
	assign results.pixel_rgb565 = q_mem[rd_q].pixel_rgb565;
	assign results.screen_x     = q_mem[rd_q].screen_x;
	assign results.screen_y     = q_mem[rd_q].screen_y;
	assign results.clear_region = q_mem[rd_q].clear_region;
	assign results.image_width  = q_mem[rd_q].image_width;
	assign results.image_height = q_mem[rd_q].image_height;
	assign results.error_code   = q_mem[rd_q].error_code;
	assign results.run_last     = q_mem[rd_q].run_last;

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= bmp565_pkg::Q_CW'(bmp565_pkg::Q_DEPTH))
		else $error("result queue overflow");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		byte_acc && bytes.file_end |=> phase_q == bmp565_pkg::PH_HEADER && pos_q == '0)
		else $error("file end did not restart the decoder");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bmp565_pkg::PH_PIXEL |-> col_q < img_w_q && row_q < img_h_q)
		else $error("pixel position outside the image");

	a_pad_state: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bmp565_pkg::PH_PAD |-> pad_q != 2'd0 && col_q == '0)
		else $error("padding state inconsistent");
`endif

endmodule

// ===== tb/tb_bmp24_stream_to_rgb565_top.sv =====
// Testbench of the BMP 24-bpp to RGB565 decoder: BMP byte streams checked against a decoding model.
module tb_bmp24_stream_to_rgb565_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bmp565_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 4;
	localparam int LIMIT_W       = 800;
	localparam int LIMIT_H       = 1023;
	// Idle percentage of each side outside the calm window
	localparam int IDLE_PCT      = 36;
	localparam int CALM_FROM     = 1500;
	localparam int CALM_TO       = 3500;
	// Receiver hold-off, started once this many bytes have gone in
	localparam int HOLD_AFTER    = 300;
	localparam int HOLD_CYCLES   = 200;
	// Cycles allowed for the decoder to settle once nothing is expected
	localparam int SETTLE_CYCLES = 8;
	// Cycles with no transaction on any channel before the run is abandoned
	localparam int STALL_LIMIT   = 3000;
	localparam int RANDOM_BYTES  = 1150;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              is_last;
	} file_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	bmp565_byte_if   byte_ch ();
	bmp565_result_if result_ch ();
	bmp565_cfg_if    cfg_ch ();

	bmp24_stream_to_rgb565_top #(
		.MAX_WIDTH  (LIMIT_W),
		.MAX_HEIGHT (LIMIT_H)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Decoding model: a private copy of the decoder state and panel size.
	// ------------------------------------------------------------------
	phase_t            dec_phase;
	logic [31:0]       hdr_pos;
	logic [31:0]       pix_offset;
	logic [31:0]       raw_w;
	logic [31:0]       raw_h;
	logic [15:0]       bpp_code;
	logic [31:0]       comp_code;
	logic              sig_ok;
	logic              top_down;
	logic [DIM_W-1:0]  col_cnt;
	logic [DIM_W-1:0]  row_cnt;
	logic [1:0]        byte_in_px;
	logic [15:0]       bg_hold;
	logic [1:0]        pad_left;
	logic [DIM_W-1:0]  off_x;
	logic [DIM_W-1:0]  off_y;
	logic [DIM_W-1:0]  panel_w;
	logic [DIM_W-1:0]  panel_h;

	result_t    byte_results[$];   // results of the byte being decoded
	result_t    decoded_q[$];      // results still owed by the decoder
	file_byte_t file_bytes_q[$];   // file bytes not yet offered

	int   bytes_taken  = 0;
	int   queued_bytes = 0;
	int   fault_count  = 0;
	int   cycle_no     = 0;
	int   idle_cycles  = 0;
	logic rx_hold      = 1'b0;
	logic calm;

	assign calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

	function automatic result_t make_result(logic [KIND_W-1:0] kind, logic [PIX_W-1:0] pix,
		logic [DIM_W-1:0] x, logic [DIM_W-1:0] y, logic clr, logic [DIM_W-1:0] iw,
		logic [DIM_W-1:0] ih, logic [ERR_W-1:0] err);
		result_t r;
		r.result_kind  = kind;
		r.pixel_rgb565 = pix;
		r.screen_x     = x;
		r.screen_y     = y;
		r.clear_region = clr;
		r.image_width  = iw;
		r.image_height = ih;
		r.error_code   = err;
		r.run_last     = 1'b0;
		return r;
	endfunction

	// Everything but the panel size returns to its start-of-file value
	function automatic void restart_file();
		dec_phase  = PH_HEADER;
		hdr_pos    = '0;
		pix_offset = '0;
		raw_w      = '0;
		raw_h      = '0;
		bpp_code   = '0;
		comp_code  = '0;
		sig_ok     = 1'b1;
		top_down   = 1'b0;
		col_cnt    = '0;
		row_cnt    = '0;
		byte_in_px = '0;
		bg_hold    = '0;
		pad_left   = '0;
		off_x      = '0;
		off_y      = '0;
	endfunction

	function automatic void flag_error(logic [ERR_W-1:0] code);
		byte_results.push_back(make_result(KIND_ERROR, '0, '0, '0, 1'b0, '0, '0, code));
		dec_phase = PH_DONE;
	endfunction

	function automatic void check_header();
		logic [31:0] h;
		h = raw_h;
		if (!sig_ok) begin
			flag_error(ERR_HEADER);
			return;
		end
		// Negative height: rows stored top-down
		if (h[31]) begin
			top_down = 1'b1;
			h = -h;
		end
		if (bpp_code != BPP_24 || comp_code != '0 || raw_w == '0 || raw_w[31] ||
			h == '0 || h[31]) begin
			flag_error(ERR_UNSUPPORTED);
			return;
		end
		if (raw_w > 32'(panel_w) || h > 32'(panel_h) || raw_w > LIMIT_W || h > LIMIT_H) begin
			flag_error(ERR_TOO_LARGE);
			return;
		end
		raw_h = h;
		off_x = DIM_W'((32'(panel_w) - raw_w) >> 1);
		off_y = DIM_W'((32'(panel_h) - h) >> 1);
		byte_results.push_back(make_result(KIND_ACCEPT, '0, '0, '0,
			(raw_w < 32'(panel_w) || h < 32'(panel_h)), raw_w[DIM_W-1:0], h[DIM_W-1:0],
			ERR_HEADER));
		dec_phase = (pix_offset <= HDR_LEN) ? PH_PIXEL : PH_SKIP;
	endfunction

	function automatic void close_row();
		row_cnt   = row_cnt + 1'b1;
		dec_phase = PH_PIXEL;
		if (32'(row_cnt) == raw_h) begin
			byte_results.push_back(make_result(KIND_COMPLETE, '0, '0, '0, 1'b0, '0, '0,
				ERR_HEADER));
			dec_phase = PH_DONE;
		end
	endfunction

	// Decode one accepted file byte and append the results it owes
	function automatic void decode_byte(logic [BYTE_W-1:0] b, logic fend);
		logic [31:0]      p;
		logic [PIX_W-1:0] pix;
		logic [DIM_W-1:0] y;
		result_t          r;
		byte_results.delete();
		case (dec_phase)
		PH_HEADER: begin
			p = hdr_pos;
			if (p == POS_SIG_B && b != SIG_B)
				sig_ok = 1'b0;
			if (p == POS_SIG_M && b != SIG_M)
				sig_ok = 1'b0;
			if (p >= POS_OFFSET && p < POS_OFFSET + 4)
				pix_offset |= 32'(b) << (8 * (p - POS_OFFSET));
			else if (p >= POS_WIDTH && p < POS_WIDTH + 4)
				raw_w |= 32'(b) << (8 * (p - POS_WIDTH));
			else if (p >= POS_HEIGHT && p < POS_HEIGHT + 4)
				raw_h |= 32'(b) << (8 * (p - POS_HEIGHT));
			else if (p >= POS_BPP && p < POS_BPP + 2)
				bpp_code |= 16'(b) << (8 * (p - POS_BPP));
			else if (p >= POS_COMP && p < POS_COMP + 4)
				comp_code |= 32'(b) << (8 * (p - POS_COMP));
			hdr_pos = p + 1;
			if (hdr_pos == HDR_LEN)
				check_header();
		end
		PH_SKIP: begin
			hdr_pos = hdr_pos + 1;
			if (hdr_pos == pix_offset)
				dec_phase = PH_PIXEL;
		end
		PH_PIXEL: begin
			if (byte_in_px == 2'd0) begin
				bg_hold    = {8'd0, b};
				byte_in_px = 2'd1;
			end else if (byte_in_px == 2'd1) begin
				bg_hold    = {b, bg_hold[7:0]};
				byte_in_px = 2'd2;
			end else begin
				// Red byte closes the triple: keep the top 5, 6 and 5 bits
				pix = {b[7:3], bg_hold[15:10], bg_hold[7:3]};
				y   = top_down ? row_cnt : raw_h[DIM_W-1:0] - 1'b1 - row_cnt;
				byte_in_px = 2'd0;
				byte_results.push_back(make_result(KIND_PIXEL, pix, off_x + col_cnt, off_y + y,
					1'b0, '0, '0, ERR_HEADER));
				col_cnt = col_cnt + 1'b1;
				if (32'(col_cnt) == raw_w) begin
					col_cnt  = '0;
					pad_left = raw_w[1:0];
					if (pad_left == 2'd0)
						close_row();
					else
						dec_phase = PH_PAD;
				end
			end
		end
		PH_PAD: begin
			pad_left = pad_left - 1'b1;
			if (pad_left == 2'd0)
				close_row();
		end
		default: ;
		endcase
		if (fend) begin
			if (dec_phase != PH_DONE)
				flag_error((dec_phase == PH_HEADER) ? ERR_HEADER : ERR_TRUNCATED);
			restart_file();
		end
		if (byte_results.size() != 0) begin
			r = byte_results.pop_back();
			r.run_last = 1'b1;
			byte_results.push_back(r);
		end
		foreach (byte_results[i])
			decoded_q.push_back(byte_results[i]);
	endfunction

	// ------------------------------------------------------------------
	// File building. A file is a 54-byte header followed by tail_len bytes;
	// keep > 0 cuts it to that many bytes, keep < 0 cuts it at random.
	// ------------------------------------------------------------------
	task automatic queue_file(input logic [7:0] sig0, input logic [7:0] sig1,
		input logic [31:0] offset, input logic [31:0] width, input logic [31:0] height,
		input logic [15:0] bpp, input logic [31:0] comp, input int tail_len, input int keep);
		logic [7:0] hdr [HDR_LEN];
		int         total;
		int         n;
		file_byte_t fb;
		foreach (hdr[i])
			hdr[i] = 8'($urandom);
		hdr[POS_SIG_B] = sig0;
		hdr[POS_SIG_M] = sig1;
		for (int i = 0; i < 4; i++) begin
			hdr[POS_OFFSET + i] = offset[8*i +: 8];
			hdr[POS_WIDTH + i]  = width[8*i +: 8];
			hdr[POS_HEIGHT + i] = height[8*i +: 8];
			hdr[POS_COMP + i]   = comp[8*i +: 8];
		end
		hdr[POS_BPP]     = bpp[7:0];
		hdr[POS_BPP + 1] = bpp[15:8];
		total = HDR_LEN + tail_len;
		if (keep < 0)
			keep = ($urandom_range(0, 2) == 0) ? $urandom_range(1, HDR_LEN - 1)
				: $urandom_range(HDR_LEN, total - 1);
		n = (keep > 0 && keep < total) ? keep : total;
		for (int i = 0; i < n; i++) begin
			fb.data    = (i < HDR_LEN) ? hdr[i] : 8'($urandom);
			fb.is_last = (i == n - 1);
			file_bytes_q.push_back(fb);
		end
		queued_bytes += n;
	endtask

	// Well-formed image: skip gap, rows of pixels with padding, then extra bytes
	task automatic queue_image(input int w, input int h, input int off, input int extra,
		input int keep);
		int rows;
		int tail;
		rows = (h < 0) ? -h : h;
		tail = ((off > HDR_LEN) ? off - HDR_LEN : 0) + rows * (3 * w + w % 4) + extra;
		queue_file(SIG_B, SIG_M, off, w, h, BPP_24, '0, tail, keep);
	endtask

	// Mostly clean images with random content; some cut short, some with a bad header
	task automatic queue_random_file();
		int          lim_w;
		int          lim_h;
		int          w;
		int          h;
		int          off;
		int          pick;
		logic [7:0]  s0;
		logic [7:0]  s1;
		logic [31:0] wv;
		logic [31:0] hv;
		logic [31:0] cv;
		logic [15:0] bv;
		lim_w = (panel_w < 10'd6) ? int'(panel_w) : 6;
		lim_h = (panel_h < 10'd4) ? int'(panel_h) : 4;
		w = $urandom_range(1, lim_w);
		h = $urandom_range(1, lim_h);
		if ($urandom_range(0, 1) == 1)
			h = -h;
		off = ($urandom_range(0, 3) == 0) ? $urandom_range(HDR_LEN + 1, HDR_LEN + 8)
			: $urandom_range(0, HDR_LEN);
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			queue_image(w, h, off, $urandom_range(0, 3), 0);
		end else if (pick < 85) begin
			queue_image(w, h, off, 0, -1);
		end else begin
			s0 = SIG_B;
			s1 = SIG_M;
			wv = w;
			hv = h;
			bv = BPP_24;
			cv = '0;
			case ($urandom_range(0, 7))
			0: s0 = 8'($urandom);
			1: s1 = 8'($urandom);
			2: bv = 16'($urandom);
			3: cv = $urandom | 32'd1;
			4: begin
				case ($urandom_range(0, 2))
				0: wv = '0;
				1: wv = wv | 32'h8000_0000;
				default: wv = $urandom;
				endcase
			end
			5: begin
				case ($urandom_range(0, 2))
				0: hv = '0;
				1: hv = 32'h8000_0000;
				default: hv = $urandom;
				endcase
			end
			6: wv = 32'(panel_w) + $urandom_range(1, 3);
			default: begin
				hv = 32'(panel_h) + $urandom_range(1, 3);
				if ($urandom_range(0, 1) == 1)
					hv = -hv;
			end
			endcase
			queue_file(s0, s1, off, wv, hv, bv, cv, $urandom_range(0, 8), 0);
		end
	endtask

	// ------------------------------------------------------------------
	// Byte driver: offer queued bytes, decode each one as it is accepted.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : byte_driver
		file_byte_t fb;
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				decode_byte(byte_ch.data_byte, byte_ch.file_end);
				bytes_taken++;
			end
			// Hold the offered byte until it is taken; keep offering during the hold-off
			if (!byte_ch.valid || byte_ch.ready) begin
				if (file_bytes_q.size() != 0 &&
					(rx_hold || calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					fb = file_bytes_q.pop_front();
					byte_ch.valid     <= 1'b1;
					byte_ch.data_byte <= fb.data;
					byte_ch.file_end  <= fb.is_last;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: each result transaction against the oldest one owed.
	// ------------------------------------------------------------------
	function automatic string result_text(result_t r);
		return $sformatf("kind=%0d pix=%h x=%0d y=%0d clr=%0b w=%0d h=%0d err=%0d last=%0b",
			r.result_kind, r.pixel_rgb565, r.screen_x, r.screen_y, r.clear_region,
			r.image_width, r.image_height, r.error_code, r.run_last);
	endfunction

	function automatic void note_fault(string msg);
		fault_count++;
		if (fault_count <= REPORT_MAX)
			$display("[%0t] %s", $realtime, msg);
	endfunction

	always @(posedge clk) begin : result_monitor
		result_t got;
		result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				// Same field order as the packed result type
				got = {result_ch.result_kind, result_ch.pixel_rgb565, result_ch.screen_x,
					result_ch.screen_y, result_ch.clear_region, result_ch.image_width,
					result_ch.image_height, result_ch.error_code, result_ch.run_last};
				if (decoded_q.size() == 0) begin
					note_fault({"unexpected result: ", result_text(got)});
				end else begin
					want = decoded_q.pop_front();
					if (got !== want)
						note_fault({"mismatch\n  expected ", result_text(want),
							"\n  actual   ", result_text(got)});
				end
			end
			result_ch.ready <= !rx_hold && (calm || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Watchdog: abandon the run after a long spell with no transaction at all
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (!arst_n || (byte_ch.valid && byte_ch.ready) ||
			(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Pressure: stall the receiver for a long stretch so the result queue
	// fills and the decoder pushes back on its byte input
	initial begin
		do
			@(negedge clk);
		while (bytes_taken < HOLD_AFTER);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Sequencing: reset, directed files, then random files under a run of
	// panel sizes. The panel is only rewritten once the decoder is idle.
	// ------------------------------------------------------------------
	task automatic wait_idle();
		do
			@(negedge clk);
		while (file_bytes_q.size() != 0 || byte_ch.valid || decoded_q.size() != 0);
		// Allow for a trailing byte that owes no result
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_panel(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wr_data   <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == REG_PANEL_WIDTH)
			panel_w = value;
		else
			panel_h = value;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_panel(input int w, input int h);
		wait_idle();
		write_panel(REG_PANEL_WIDTH, DIM_W'(w));
		write_panel(REG_PANEL_HEIGHT, DIM_W'(h));
		// Queue the next files away from the clock edge
		@(negedge clk);
	endtask

	initial begin
		int random_from;
		int pw;
		int ph;

		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.file_end  = 1'b0;
		result_ch.ready   = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.reg_index  = REG_PANEL_WIDTH;
		cfg_ch.wr_data    = '0;
		panel_w           = PANEL_WIDTH_RST;
		panel_h           = PANEL_HEIGHT_RST;
		restart_file();

		// Directed files at the reset panel size of 800 by 480
		queue_file(SIG_B, SIG_M, HDR_LEN, 2, 2, BPP_24, '0, 0, 5);        // header cut short
		queue_file(SIG_B, 8'h58, HDR_LEN, 2, 2, BPP_24, '0, 6, 0);        // bad signature
		queue_file(8'h62, SIG_M, HDR_LEN, 1, 1, BPP_24, '0, 3, 0);
		queue_file(SIG_B, SIG_M, HDR_LEN, 2, 2, 16'd16, '0, 4, 0);        // wrong depth
		queue_file(SIG_B, SIG_M, HDR_LEN, 2, 2, BPP_24, 32'd3, 4, 0);     // compressed
		queue_file(SIG_B, SIG_M, HDR_LEN, 2, 32'h8000_0000, BPP_24, '0, 2, 0);
		queue_file(SIG_B, SIG_M, HDR_LEN, 0, 2, BPP_24, '0, 2, 0);        // zero width
		queue_file(SIG_B, SIG_M, HDR_LEN, 32'hFFFF_FFFE, 2, BPP_24, '0, 2, 0);
		queue_file(SIG_B, SIG_M, HDR_LEN, 801, 2, BPP_24, '0, 2, 0);      // too wide
		queue_file(SIG_B, SIG_M, HDR_LEN, 2, -481, BPP_24, '0, 2, 0);     // too tall
		queue_image(3, 2, 0, 2, 0);                 // small offset, padded rows, trailing bytes
		queue_image(5, -3, HDR_LEN + 6, 0, 0);      // top-down with a skipped gap
		queue_image(4, 1, HDR_LEN, 0, HDR_LEN + 7); // cut inside a pixel
		queue_image(2, 2, HDR_LEN + 4, 0, HDR_LEN + 2); // cut inside the gap
		queue_image(2, 1, HDR_LEN, 0, HDR_LEN);     // file ends on the last header byte
		queue_image(800, 1, HDR_LEN, 1, 0);         // full panel width

		#1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Tallest panel: a single bottom-up column reaching the top row
		set_panel(800, 1023);
		queue_image(1, 1023, HDR_LEN, 0, 0);
		queue_image(3, -2, HDR_LEN, 1, 0);

		// Smallest panel: exact fit, then too large either way
		set_panel(1, 1);
		queue_image(1, 1, HDR_LEN, 0, 0);
		queue_image(1, -1, HDR_LEN + 1, 2, 0);
		queue_file(SIG_B, SIG_M, HDR_LEN, 2, 1, BPP_24, '0, 3, 0);
		queue_file(SIG_B, SIG_M, HDR_LEN, 1, 2, BPP_24, '0, 3, 0);

		// Random files, a fresh panel size every few files
		random_from = queued_bytes;
		while (queued_bytes - random_from < RANDOM_BYTES) begin
			pw = ($urandom_range(0, 4) == 0) ? 800 : $urandom_range(1, 10);
			ph = ($urandom_range(0, 4) == 0) ? 1023 : $urandom_range(1, 6);
			set_panel(pw, ph);
			repeat ($urandom_range(3, 8))
				queue_random_file();
		end

		wait_idle();
		if (fault_count == 0 && decoded_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
